[rtl/rhr_pkg.sv]
// Shared types, constants and conversion functions for the RGB565 hue rotator.
// No dependencies; every rtl file refers to this package by scoped names.
package rhr_pkg;

    localparam int HUE_SEXT = 3840;   // 60 degrees in 1/64-degree units
    localparam int HUE_FULL = 23040;  // 360 degrees in 1/64-degree units
    localparam int FRAC_W   = 17;     // Q0.16 fraction, 1.0 = 65536
    localparam int DIV_N_W  = 28;     // sector-hue dividend width
    localparam int Q_W      = 12;     // sector-hue quotient width (0..3840)
    localparam int HUE_W    = 15;     // hue width (0..23039)

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_ch_t;

    // Per-pixel values that ride alongside the datapath from front to back.
    typedef struct packed {
        logic [15:0]       pixel;
        logic              bypass;
        logic [8:0]        shift;
        logic [FRAC_W-1:0] delta;
        logic [FRAC_W-1:0] mn;
        logic              neg;
        max_ch_t           max_ch;
    } side_t;

    // 5-bit code to Q0.16 fraction, rounded half up.
    // Since 65536 = 31 * 2114 + 2, the quotient is 2114 * code plus a correction
    // of floor((2 * code + 15) / 31), which is 0, 1 or 2.
    function automatic logic [FRAC_W-1:0] frac5(input logic [4:0] code);
        logic [6:0] n;
        logic [1:0] corr;
        n = {1'b0, code, 1'b0} + 7'd15;
        if (n >= 7'd62)
            corr = 2'd2;
        else if (n >= 7'd31)
            corr = 2'd1;
        else
            corr = 2'd0;
        return FRAC_W'(code) * FRAC_W'(2114) + FRAC_W'(corr);
    endfunction

    // 6-bit code to Q0.16 fraction, rounded half up.
    // Since 65536 = 63 * 1040 + 16, the quotient is 1040 * code plus
    // floor((16 * code + 31) / 63), taken by a reciprocal multiplication.
    function automatic logic [FRAC_W-1:0] frac6(input logic [5:0] code);
        logic [10:0] n;
        logic [21:0] p;
        n = {1'b0, code, 4'd0} + 11'd31;
        p = 22'(n) * 22'd1041;
        return FRAC_W'(code) * FRAC_W'(1040) + FRAC_W'(p[21:16]);
    endfunction

    // Q0.16 fraction back to a 5-bit code, rounded half up.
    function automatic logic [4:0] code5(input logic [FRAC_W-1:0] f);
        logic [22:0] p;
        p = ({6'd0, f} << 5) - {6'd0, f} + 23'd32768;
        return p[20:16];
    endfunction

    // Q0.16 fraction back to a 6-bit code, rounded half up.
    function automatic logic [5:0] code6(input logic [FRAC_W-1:0] f);
        logic [23:0] p;
        p = ({7'd0, f} << 6) - {7'd0, f} + 24'd32768;
        return p[21:16];
    endfunction

endpackage

[rtl/rhr_front.sv]
// Front end of the hue rotator: unpack, fractions, max/min and the divider dividend.
// Depends on rhr_pkg.
module rhr_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [15:0]                  pixel,
    input  logic [8:0]                   shift,
    output logic                         out_valid,
    output rhr_pkg::side_t               side,
    output logic [rhr_pkg::DIV_N_W-1:0]  dividend
);

    logic                        v1_reg, v2_reg, v3_reg;
    logic [15:0]                 pix1_reg;
    logic [8:0]                  sh1_reg;
    logic [rhr_pkg::FRAC_W-1:0]  rf1_reg, gf1_reg, bf1_reg;
    rhr_pkg::side_t              side2_reg, side3_reg, side2_next;
    logic [rhr_pkg::FRAC_W-1:0]  mag2_reg, mag2_next;
    logic [rhr_pkg::DIV_N_W-1:0] div3_reg, div3_next;

    logic [rhr_pkg::FRAC_W-1:0]  mx, mn;
    logic [rhr_pkg::FRAC_W:0]    diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix1_reg  <= pixel;
            sh1_reg   <= shift;
            rf1_reg   <= rhr_pkg::frac5(pixel[15:11]);
            gf1_reg   <= rhr_pkg::frac6(pixel[10:5]);
            bf1_reg   <= rhr_pkg::frac5(pixel[4:0]);
            side2_reg <= side2_next;
            mag2_reg  <= mag2_next;
            side3_reg <= side2_reg;
            div3_reg  <= div3_next;
        end
    end

    // Red wins ties for the maximum, then green.
    always_comb
    begin
        side2_next        = '0;
        side2_next.pixel  = pix1_reg;
        side2_next.shift  = sh1_reg;
        side2_next.bypass = (sh1_reg == 9'd0);
        mn = rf1_reg;
        if (gf1_reg < mn)
            mn = gf1_reg;
        if (bf1_reg < mn)
            mn = bf1_reg;
        if (rf1_reg >= gf1_reg && rf1_reg >= bf1_reg)
        begin
            side2_next.max_ch = rhr_pkg::MAX_RED;
            mx   = rf1_reg;
            diff = {1'b0, gf1_reg} - {1'b0, bf1_reg};
        end
        else if (gf1_reg >= bf1_reg)
        begin
            side2_next.max_ch = rhr_pkg::MAX_GREEN;
            mx   = gf1_reg;
            diff = {1'b0, bf1_reg} - {1'b0, rf1_reg};
        end
        else
        begin
            side2_next.max_ch = rhr_pkg::MAX_BLUE;
            mx   = bf1_reg;
            diff = {1'b0, rf1_reg} - {1'b0, gf1_reg};
        end
        side2_next.delta = mx - mn;
        side2_next.mn    = mn;
        side2_next.neg   = diff[rhr_pkg::FRAC_W];
        mag2_next = diff[rhr_pkg::FRAC_W] ? rhr_pkg::FRAC_W'(-diff)
                                          : diff[rhr_pkg::FRAC_W-1:0];
    end

    // Dividend of the rounded sector hue: mag * 3840 + delta / 2.
    always_comb
    begin
        div3_next = rhr_pkg::DIV_N_W'(mag2_reg) * rhr_pkg::DIV_N_W'(rhr_pkg::HUE_SEXT)
                  + rhr_pkg::DIV_N_W'(side2_reg.delta >> 1);
    end

    assign out_valid = v3_reg;
    assign side      = side3_reg;
    assign dividend  = div3_reg;

endmodule

[rtl/rhr_divider.sv]
// Pipelined restoring divider for the sector hue, one quotient bit per stage.
// Depends on rhr_pkg; the side information travels with each quotient.
module rhr_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  rhr_pkg::side_t               in_side,
    input  logic [rhr_pkg::DIV_N_W-1:0]  dividend,
    output logic                         out_valid,
    output rhr_pkg::side_t               out_side,
    output logic [rhr_pkg::Q_W-1:0]      quotient
);

    localparam int NS = rhr_pkg::Q_W;

    logic [NS-1:0]               vld_reg;
    logic [rhr_pkg::DIV_N_W-1:0] rem_reg [NS];
    logic [NS-1:0]               q_reg   [NS];
    rhr_pkg::side_t              side_reg [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic                        v_prev;
        logic [rhr_pkg::DIV_N_W-1:0] rem_prev, rem_next;
        logic [NS-1:0]               q_prev, q_next;
        rhr_pkg::side_t              side_prev;
        logic [rhr_pkg::DIV_N_W:0]   trial;

        if (s == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = dividend;
            assign q_prev    = '0;
            assign side_prev = in_side;
        end
        else
        begin : g_rest
            assign v_prev    = vld_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign q_prev    = q_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        // Stage s decides quotient bit NS-1-s.
        always_comb
        begin
            trial    = (rhr_pkg::DIV_N_W+1)'(side_prev.delta) << (NS - 1 - s);
            rem_next = rem_prev;
            q_next   = q_prev;
            if ({1'b0, rem_prev} >= trial)
            begin
                rem_next          = rem_prev - trial[rhr_pkg::DIV_N_W-1:0];
                q_next[NS-1-s]    = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                q_reg[s]    <= q_next;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign quotient  = q_reg[NS-1];

endmodule

[rtl/rhr_back.sv]
// Back end of the hue rotator: hue assembly, rotation, six-sector HSV-to-RGB, repacking.
// Depends on rhr_pkg; the last stage is the output register of the block.
module rhr_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  rhr_pkg::side_t           in_side,
    input  logic [rhr_pkg::Q_W-1:0]  quotient,
    output logic                     out_valid,
    output logic [15:0]              pixel
);

    localparam int NB = 7;

    logic [NB-1:0]  vld_reg;
    rhr_pkg::side_t side_reg [NB];

    logic [rhr_pkg::HUE_W-1:0]  h1_reg, h1_next;
    logic [rhr_pkg::HUE_W-1:0]  hu2_reg, hu2_next;
    logic [16:0]                sum2;
    logic [2:0]                 sec3_reg, sec4_reg, sec5_reg, sec6_reg, sec3_next;
    logic [11:0]                w3_reg, w3_next, off3;
    logic [28:0]                p4_reg, p4_next;
    logic [19:0]                x5_reg, x5_next;
    logic [16:0]                q5_reg, q5_next;
    logic [32:0]                prod5;
    logic [16:0]                xv6_reg, xv6_next;
    logic [20:0]                rem6;
    logic [15:0]                pix7_reg, pix7_next;
    logic [rhr_pkg::FRAC_W-1:0] ro, go, bo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NB-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int i = 1; i < NB; i++)
                side_reg[i] <= side_reg[i-1];
            h1_reg   <= h1_next;
            hu2_reg  <= hu2_next;
            sec3_reg <= sec3_next;
            w3_reg   <= w3_next;
            sec4_reg <= sec3_reg;
            p4_reg   <= p4_next;
            sec5_reg <= sec4_reg;
            x5_reg   <= x5_next;
            q5_reg   <= q5_next;
            sec6_reg <= sec5_reg;
            xv6_reg  <= xv6_next;
            pix7_reg <= pix7_next;
        end
    end

    // Hue from the sector quotient; a negative red-sector hue wraps by a full turn.
    always_comb
    begin
        h1_next = '0;
        if (in_side.delta != '0)
        begin
            case (in_side.max_ch)
                rhr_pkg::MAX_RED:
                    if (in_side.neg && quotient != '0)
                        h1_next = rhr_pkg::HUE_W'(rhr_pkg::HUE_FULL) - rhr_pkg::HUE_W'(quotient);
                    else
                        h1_next = rhr_pkg::HUE_W'(quotient);
                rhr_pkg::MAX_GREEN:
                    if (in_side.neg)
                        h1_next = rhr_pkg::HUE_W'(2 * rhr_pkg::HUE_SEXT)
                                - rhr_pkg::HUE_W'(quotient);
                    else
                        h1_next = rhr_pkg::HUE_W'(2 * rhr_pkg::HUE_SEXT)
                                + rhr_pkg::HUE_W'(quotient);
                default:
                    if (in_side.neg)
                        h1_next = rhr_pkg::HUE_W'(4 * rhr_pkg::HUE_SEXT)
                                - rhr_pkg::HUE_W'(quotient);
                    else
                        h1_next = rhr_pkg::HUE_W'(4 * rhr_pkg::HUE_SEXT)
                                + rhr_pkg::HUE_W'(quotient);
            endcase
        end
    end

    // Rotation; the sum stays below three full turns.
    always_comb
    begin
        sum2 = 17'(h1_reg) + {2'd0, side_reg[0].shift, 6'd0};
        if (sum2 >= 17'(2 * rhr_pkg::HUE_FULL))
            hu2_next = rhr_pkg::HUE_W'(sum2 - 17'(2 * rhr_pkg::HUE_FULL));
        else if (sum2 >= 17'(rhr_pkg::HUE_FULL))
            hu2_next = rhr_pkg::HUE_W'(sum2 - 17'(rhr_pkg::HUE_FULL));
        else
            hu2_next = rhr_pkg::HUE_W'(sum2);
    end

    // Sector and the ramp weight 3840 - |(hue mod 7680) - 3840|.
    always_comb
    begin
        if (hu2_reg >= rhr_pkg::HUE_W'(5 * rhr_pkg::HUE_SEXT))
            sec3_next = 3'd5;
        else if (hu2_reg >= rhr_pkg::HUE_W'(4 * rhr_pkg::HUE_SEXT))
            sec3_next = 3'd4;
        else if (hu2_reg >= rhr_pkg::HUE_W'(3 * rhr_pkg::HUE_SEXT))
            sec3_next = 3'd3;
        else if (hu2_reg >= rhr_pkg::HUE_W'(2 * rhr_pkg::HUE_SEXT))
            sec3_next = 3'd2;
        else if (hu2_reg >= rhr_pkg::HUE_W'(rhr_pkg::HUE_SEXT))
            sec3_next = 3'd1;
        else
            sec3_next = 3'd0;
        off3 = 12'(hu2_reg - rhr_pkg::HUE_W'(sec3_next)
                           * rhr_pkg::HUE_W'(rhr_pkg::HUE_SEXT));
        w3_next = sec3_next[0] ? 12'(rhr_pkg::HUE_SEXT) - off3 : off3;
    end

    // Product for the secondary channel, rounded by half a sector.
    always_comb
    begin
        p4_next = 29'(side_reg[2].delta) * 29'(w3_reg) + 29'(rhr_pkg::HUE_SEXT / 2);
    end

    // Division by 3840 = 256 * 15: shift, then a reciprocal estimate that is low by at most two.
    always_comb
    begin
        x5_next = p4_reg[27:8];
        prod5   = 33'(x5_next) * 33'd4369;
        q5_next = prod5[32:16];
    end

    always_comb
    begin
        rem6 = 21'(x5_reg) - ((21'(q5_reg) << 4) - 21'(q5_reg));
        if (rem6 >= 21'd30)
            xv6_next = q5_reg + 17'd2;
        else if (rem6 >= 21'd15)
            xv6_next = q5_reg + 17'd1;
        else
            xv6_next = q5_reg;
    end

    // Six-sector mapping, add the minimum back and requantize; a bypassed pixel passes unchanged.
    always_comb
    begin
        ro = '0;
        go = '0;
        bo = '0;
        case (sec6_reg)
            3'd0: begin ro = side_reg[5].delta; go = xv6_reg; end
            3'd1: begin ro = xv6_reg; go = side_reg[5].delta; end
            3'd2: begin go = side_reg[5].delta; bo = xv6_reg; end
            3'd3: begin go = xv6_reg; bo = side_reg[5].delta; end
            3'd4: begin ro = xv6_reg; bo = side_reg[5].delta; end
            default: begin ro = side_reg[5].delta; bo = xv6_reg; end
        endcase
        if (side_reg[5].bypass)
            pix7_next = side_reg[5].pixel;
        else
            pix7_next = {rhr_pkg::code5(ro + side_reg[5].mn),
                         rhr_pkg::code6(go + side_reg[5].mn),
                         rhr_pkg::code5(bo + side_reg[5].mn)};
    end

    assign out_valid = vld_reg[NB-1];
    assign pixel     = pix7_reg;

endmodule

[rtl/rgb565_hue_rotate.sv]
// Top level of the RGB565 hue rotator: configuration register and pipeline assembly.
// Depends on rhr_pkg, rhr_front, rhr_divider and rhr_back.
//
// This block rotates the hue of a stream of RGB565 pixels by hue_shift degrees. It accepts
// one pixel beat per clock and delivers one pixel beat per clock unless out_ready stalls the
// output. Its pipeline holds three front stages (unpack, max/min, dividend), twelve divider
// stages that resolve one bit of the sector hue each, and seven back stages (hue, rotation,
// sector, ramp product, two for the division by 3840, repack), the last of which is the
// output register. The whole pipeline advances whenever the output register is empty or
// being drained, so a stall on out_ready freezes every stage in place and no beat is lost or
// duplicated. A hue_shift of zero passes pixels through unchanged, though still through every
// stage. Write hue_shift only while no beats are in flight.
module rgb565_hue_rotate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] pixel_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pixel_out
);

    logic [8:0] hue_shift_reg;

    // Global advance: every stage moves when the output register can take a new beat.
    logic en;

    logic                         front_valid;
    rhr_pkg::side_t               front_side;
    logic [rhr_pkg::DIV_N_W-1:0]  front_dividend;

    logic                         div_valid;
    rhr_pkg::side_t               div_side;
    logic [rhr_pkg::Q_W-1:0]      div_quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hue_shift_reg <= '0;
        else if (cfg_wr_en)
            hue_shift_reg <= cfg_wr_data;
    end

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    rhr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .pixel     (pixel_in),
        .shift     (hue_shift_reg),
        .out_valid (front_valid),
        .side      (front_side),
        .dividend  (front_dividend)
    );

    rhr_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_side   (front_side),
        .dividend  (front_dividend),
        .out_valid (div_valid),
        .out_side  (div_side),
        .quotient  (div_quotient)
    );

    rhr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_side   (div_side),
        .quotient  (div_quotient),
        .out_valid (out_valid),
        .pixel     (pixel_out)
    );

endmodule
